// ===== hw/rtl/dkse_pkg.sv =====
// Shared types and constants of the date key sort engine.
package dkse_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int TAG_W   = 16;
   localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
   localparam int REC_W   = KEY_W + TAG_W;
   localparam int CNT_W   = 12;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [1:0] {
      ALG_BUBBLE    = 2'd0,
      ALG_SELECTION = 2'd1,
      ALG_INSERTION = 2'd2,
      ALG_SPARE     = 2'd3
   } alg_type;

   // Index register that supplies a memory address.
   typedef enum logic [1:0] {
      ADDR_I,
      ADDR_J,
      ADDR_J_PREV,
      ADDR_BEST
   } addr_sel_type;

   typedef enum logic [1:0] {
      DATA_A,
      DATA_B,
      DATA_HELD
   } data_sel_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_START,
      ST_BUB_NEXT,
      ST_BUB_RD,
      ST_BUB_WAIT,
      ST_BUB_CMP,
      ST_BUB_WR,
      ST_SEL_INIT,
      ST_SEL_WAITA,
      ST_SEL_RD,
      ST_SEL_WAIT,
      ST_SEL_CMP,
      ST_SEL_WAITI,
      ST_SEL_SWAP,
      ST_SEL_SWAP2,
      ST_INS_RD,
      ST_INS_WAIT,
      ST_INS_TRD,
      ST_INS_TWAIT,
      ST_INS_CMP,
      ST_INS_PLACE,
      ST_OUT_RD,
      ST_OUT_WAIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         store_in;     // write the incoming word at the fill count
      logic         clr_count;
      logic         clr_counts;
      logic         rd_en;
      addr_sel_type rd_sel;
      logic         wr_en;
      addr_sel_type wr_sel;
      data_sel_type wr_data_sel;
      logic         cap_a;
      logic         cap_b;
      logic         cap_held;
      logic         b_to_a;
      logic         inc_cmp;
      logic         inc_mov;
      logic         set_i_zero;
      logic         set_i_one;
      logic         inc_i;
      logic         set_j_i1;     // j = i + 1
      logic         set_j_i;      // j = i
      logic         inc_j;
      logic         dec_j;
      logic         set_best_i;
      logic         set_best_j;
      logic         set_lim_n;
      logic         dec_lim;
      logic         clr_swapped;
      logic         set_swapped;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic a_later_b;     // key A > key B
      logic held_later_b;  // key held > key B
      logic i_lt_lim;      // i + 1 < lim
      logic i_lt_n;
      logic j_lt_n;
      logic j_zero;
      logic best_ne_i;
      logic swapped;
      logic last_rec;      // i + 1 == n
   } sts_type;

endpackage

// ===== hw/rtl/date_key_sort_engine_unit.sv =====
// Top level of the date key sort engine: register, controller and datapath.
// Records are taken one per cycle while loading; the final record starts the sort.
// Sorting runs in place in the record memory, reading each pair into registers before
// comparing; a bubble pass ends the sort once it makes no swap. Output then reads the
// sorted words one at a time and holds each while the output stalls.
// Input stalls from the final record until the last word is loaded; a synchronous
// active-high reset clears control state, counts and the algorithm, not the memory.
module date_key_sort_engine_unit #(
   parameter int MAX_RECORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [13:0] req_birth_year,
   input  logic [3:0]  req_birth_month,
   input  logic [4:0]  req_birth_day,
   input  logic [15:0] req_record_tag,
   input  logic        req_final_record,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [13:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [15:0] rsp_out_tag,
   output logic [11:0] rsp_comparisons,
   output logic [11:0] rsp_moves,
   output logic        rsp_last_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_algorithm
);
   dkse_pkg::alg_type alg_ff;
   dkse_pkg::cmd_type cmd;
   dkse_pkg::sts_type sts;
   logic [dkse_pkg::REC_W-1:0] out_rec;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) alg_ff <= dkse_pkg::ALG_BUBBLE;
      else if (csr_valid) alg_ff <= dkse_pkg::alg_type'(csr_algorithm);
   end

   dkse_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_final_record,
      .rsp_stall, .rsp_valid, .rsp_last_out,
      .alg(alg_ff), .sts, .cmd
   );

   dkse_datapath #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_rec({req_birth_year, req_birth_month, req_birth_day, req_record_tag}),
      .out_rec, .out_cmp(rsp_comparisons), .out_mov(rsp_moves)
   );

   assign {rsp_out_year, rsp_out_month, rsp_out_day, rsp_out_tag} = out_rec;
endmodule

// ===== hw/rtl/dkse_datapath.sv =====
// Record memory, index registers, compare logic and counters.
module dkse_datapath #(
   parameter int MAX_RECORDS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dkse_pkg::cmd_type             cmd,
   output dkse_pkg::sts_type             sts,
   input  logic [dkse_pkg::REC_W-1:0]    in_rec,
   output logic [dkse_pkg::REC_W-1:0]    out_rec,
   output logic [dkse_pkg::CNT_W-1:0]    out_cmp,
   output logic [dkse_pkg::CNT_W-1:0]    out_mov
);
   localparam int AW = $clog2(MAX_RECORDS);
   localparam int NW = $clog2(MAX_RECORDS + 1);
   localparam int RW = dkse_pkg::REC_W;
   localparam int TW = dkse_pkg::TAG_W;
   localparam logic [NW-1:0] N_MAX = NW'(MAX_RECORDS);

   logic [RW-1:0] mem [MAX_RECORDS];
   logic [RW-1:0] rd_data_ff;
   logic [RW-1:0] a_ff, b_ff, held_ff;
   logic [NW-1:0] n_ff, i_ff, j_ff, best_ff, lim_ff;
   logic [NW-1:0] j_prev, rd_idx, wr_idx;
   logic [dkse_pkg::CNT_W-1:0] cmp_ff, mov_ff;
   logic swapped_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [RW-1:0] wr_data;
   logic          wr_en;

   assign j_prev = j_ff - 1'b1;

   always_comb begin
      case (cmd.rd_sel)
         dkse_pkg::ADDR_I:      rd_idx = i_ff;
         dkse_pkg::ADDR_J:      rd_idx = j_ff;
         dkse_pkg::ADDR_J_PREV: rd_idx = j_prev;
         default:               rd_idx = best_ff;
      endcase
      case (cmd.wr_sel)
         dkse_pkg::ADDR_I:      wr_idx = i_ff;
         dkse_pkg::ADDR_J:      wr_idx = j_ff;
         dkse_pkg::ADDR_J_PREV: wr_idx = j_prev;
         default:               wr_idx = best_ff;
      endcase
      case (cmd.wr_data_sel)
         dkse_pkg::DATA_A: wr_data = a_ff;
         dkse_pkg::DATA_B: wr_data = b_ff;
         default:          wr_data = held_ff;
      endcase
      rd_addr = rd_idx[AW-1:0];
      wr_addr = wr_idx[AW-1:0];
      wr_en   = cmd.wr_en;
      if (cmd.store_in) begin
         wr_en   = (n_ff != N_MAX);
         wr_addr = n_ff[AW-1:0];
         wr_data = in_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_a) a_ff <= rd_data_ff;
      if (cmd.b_to_a) a_ff <= b_ff;
      if (cmd.cap_b) b_ff <= rd_data_ff;
      if (cmd.cap_held) held_ff <= rd_data_ff;
      if (cmd.out_load) begin
         out_rec <= rd_data_ff;
         out_cmp <= cmp_ff;
         out_mov <= mov_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0; i_ff <= '0; j_ff <= '0; best_ff <= '0; lim_ff <= '0;
         cmp_ff <= '0; mov_ff <= '0; swapped_ff <= 1'b0;
      end else begin
         if (cmd.store_in && n_ff != N_MAX) n_ff <= n_ff + 1'b1;
         if (cmd.clr_count) n_ff <= '0;
         if (cmd.set_i_zero) i_ff <= '0;
         if (cmd.set_i_one) i_ff <= NW'(1);
         if (cmd.inc_i) i_ff <= i_ff + 1'b1;
         if (cmd.set_j_i1) j_ff <= i_ff + 1'b1;
         if (cmd.set_j_i) j_ff <= i_ff;
         if (cmd.inc_j) j_ff <= j_ff + 1'b1;
         if (cmd.dec_j) j_ff <= j_prev;
         if (cmd.set_best_i) best_ff <= i_ff;
         if (cmd.set_best_j) best_ff <= j_ff;
         if (cmd.set_lim_n) lim_ff <= n_ff;
         if (cmd.dec_lim) lim_ff <= lim_ff - 1'b1;
         if (cmd.clr_swapped) swapped_ff <= 1'b0;
         if (cmd.set_swapped) swapped_ff <= 1'b1;
         if (cmd.clr_counts) begin
            cmp_ff <= '0; mov_ff <= '0;
         end else begin
            if (cmd.inc_cmp && cmp_ff != dkse_pkg::CNT_MAX) cmp_ff <= cmp_ff + 1'b1;
            if (cmd.inc_mov && mov_ff != dkse_pkg::CNT_MAX) mov_ff <= mov_ff + 1'b1;
         end
      end
   end

   always_comb begin
      sts.a_later_b    = a_ff[RW-1:TW] > b_ff[RW-1:TW];
      sts.held_later_b = held_ff[RW-1:TW] > b_ff[RW-1:TW];
      sts.i_lt_lim     = ({1'b0, i_ff} + 1'b1) < {1'b0, lim_ff};
      sts.i_lt_n       = i_ff < n_ff;
      sts.j_lt_n       = j_ff < n_ff;
      sts.j_zero       = (j_ff == '0);
      sts.best_ne_i    = (best_ff != i_ff);
      sts.swapped      = swapped_ff;
      sts.last_rec     = ({1'b0, i_ff} + 1'b1) == {1'b0, n_ff};
   end
endmodule

// ===== hw/rtl/dkse_ctrl.sv =====
// Sequencer that runs loading, the three sorts and the output sweep.
module dkse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_final_record,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic                 rsp_last_out,
   input  dkse_pkg::alg_type    alg,
   input  dkse_pkg::sts_type    sts,
   output dkse_pkg::cmd_type    cmd
);
   dkse_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in, last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dkse_pkg::ST_LOAD;
         rsp_valid_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_last_out = last_ff;
   assign req_stall    = (state_ff != dkse_pkg::ST_LOAD);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dkse_pkg::ST_LOAD:
            if (req_valid && req_final_record) state_in = dkse_pkg::ST_START;
         dkse_pkg::ST_START:
            case (alg)
               dkse_pkg::ALG_SELECTION: state_in = dkse_pkg::ST_SEL_INIT;
               dkse_pkg::ALG_INSERTION: state_in = dkse_pkg::ST_INS_RD;
               default: state_in = dkse_pkg::ST_BUB_NEXT;
            endcase
         dkse_pkg::ST_BUB_NEXT:
            if (sts.i_lt_lim) state_in = dkse_pkg::ST_BUB_RD;
            else if (!sts.swapped) state_in = dkse_pkg::ST_OUT_RD;
         dkse_pkg::ST_BUB_RD:   state_in = dkse_pkg::ST_BUB_WAIT;
         dkse_pkg::ST_BUB_WAIT: state_in = dkse_pkg::ST_BUB_CMP;
         dkse_pkg::ST_BUB_CMP:
            state_in = sts.a_later_b ? dkse_pkg::ST_BUB_WR : dkse_pkg::ST_BUB_NEXT;
         dkse_pkg::ST_BUB_WR:   state_in = dkse_pkg::ST_BUB_NEXT;
         dkse_pkg::ST_SEL_INIT:
            state_in = sts.i_lt_lim ? dkse_pkg::ST_SEL_WAITA : dkse_pkg::ST_OUT_RD;
         dkse_pkg::ST_SEL_WAITA: state_in = dkse_pkg::ST_SEL_RD;
         dkse_pkg::ST_SEL_RD:
            if (sts.j_lt_n) state_in = dkse_pkg::ST_SEL_WAIT;
            else if (sts.best_ne_i) state_in = dkse_pkg::ST_SEL_WAITI;
            else state_in = dkse_pkg::ST_SEL_INIT;
         dkse_pkg::ST_SEL_WAIT:  state_in = dkse_pkg::ST_SEL_CMP;
         dkse_pkg::ST_SEL_CMP:   state_in = dkse_pkg::ST_SEL_RD;
         dkse_pkg::ST_SEL_WAITI: state_in = dkse_pkg::ST_SEL_SWAP;
         dkse_pkg::ST_SEL_SWAP:  state_in = dkse_pkg::ST_SEL_SWAP2;
         dkse_pkg::ST_SEL_SWAP2: state_in = dkse_pkg::ST_SEL_INIT;
         dkse_pkg::ST_INS_RD:
            state_in = sts.i_lt_n ? dkse_pkg::ST_INS_WAIT : dkse_pkg::ST_OUT_RD;
         dkse_pkg::ST_INS_WAIT:  state_in = dkse_pkg::ST_INS_TRD;
         dkse_pkg::ST_INS_TRD:
            state_in = sts.j_zero ? dkse_pkg::ST_INS_PLACE : dkse_pkg::ST_INS_TWAIT;
         dkse_pkg::ST_INS_TWAIT: state_in = dkse_pkg::ST_INS_CMP;
         dkse_pkg::ST_INS_CMP:
            state_in = sts.held_later_b ? dkse_pkg::ST_INS_PLACE : dkse_pkg::ST_INS_TRD;
         dkse_pkg::ST_INS_PLACE: state_in = dkse_pkg::ST_INS_RD;
         dkse_pkg::ST_OUT_RD:
            state_in = sts.i_lt_n ? dkse_pkg::ST_OUT_WAIT : dkse_pkg::ST_LOAD;
         dkse_pkg::ST_OUT_WAIT:
            if (!rsp_valid_ff || !rsp_stall) state_in = dkse_pkg::ST_OUT_RD;
         default: state_in = dkse_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      last_in = last_ff;
      case (state_ff)
         dkse_pkg::ST_LOAD: begin
            cmd.store_in = req_valid;
            cmd.clr_counts = req_valid && req_final_record;
         end
         dkse_pkg::ST_START: begin
            cmd.set_lim_n = 1'b1;
            cmd.clr_swapped = 1'b1;
            cmd.set_i_zero = (alg != dkse_pkg::ALG_INSERTION);
            cmd.set_i_one = (alg == dkse_pkg::ALG_INSERTION);
         end
         dkse_pkg::ST_BUB_NEXT: begin
            if (sts.i_lt_lim) begin
               cmd.rd_en = 1'b1; cmd.rd_sel = dkse_pkg::ADDR_I;
               cmd.set_j_i1 = 1'b1;
            end else begin
               // End of a pass: another pass only if this one swapped.
               cmd.set_i_zero = 1'b1;
               if (sts.swapped) begin
                  cmd.dec_lim = 1'b1;
                  cmd.clr_swapped = 1'b1;
               end
            end
         end
         dkse_pkg::ST_BUB_RD: begin
            cmd.cap_a = 1'b1;
            cmd.rd_en = 1'b1; cmd.rd_sel = dkse_pkg::ADDR_J;
         end
         dkse_pkg::ST_BUB_WAIT: cmd.cap_b = 1'b1;
         dkse_pkg::ST_BUB_CMP: begin
            cmd.inc_cmp = 1'b1;
            if (sts.a_later_b) begin
               cmd.wr_en = 1'b1; cmd.wr_sel = dkse_pkg::ADDR_I;
               cmd.wr_data_sel = dkse_pkg::DATA_B;
               cmd.inc_mov = 1'b1; cmd.set_swapped = 1'b1;
            end else begin
               cmd.inc_i = 1'b1;
            end
         end
         dkse_pkg::ST_BUB_WR: begin
            cmd.wr_en = 1'b1; cmd.wr_sel = dkse_pkg::ADDR_J;
            cmd.wr_data_sel = dkse_pkg::DATA_A;
            cmd.inc_i = 1'b1;
         end
         dkse_pkg::ST_SEL_INIT: begin
            if (sts.i_lt_lim) begin
               cmd.rd_en = 1'b1; cmd.rd_sel = dkse_pkg::ADDR_I;
               cmd.set_j_i1 = 1'b1; cmd.set_best_i = 1'b1;
            end else begin
               cmd.set_i_zero = 1'b1;
            end
         end
         // Register A always holds the smallest record found so far.
         dkse_pkg::ST_SEL_WAITA: cmd.cap_a = 1'b1;
         dkse_pkg::ST_SEL_RD: begin
            if (sts.j_lt_n) begin
               cmd.rd_en = 1'b1; cmd.rd_sel = dkse_pkg::ADDR_J;
            end else if (sts.best_ne_i) begin
               cmd.rd_en = 1'b1; cmd.rd_sel = dkse_pkg::ADDR_I;
            end else begin
               cmd.inc_i = 1'b1;
            end
         end
         dkse_pkg::ST_SEL_WAIT: cmd.cap_b = 1'b1;
         dkse_pkg::ST_SEL_CMP: begin
            cmd.inc_cmp = 1'b1;
            cmd.inc_j = 1'b1;
            if (sts.a_later_b) begin
               cmd.set_best_j = 1'b1;
               cmd.b_to_a = 1'b1;
            end
         end
         dkse_pkg::ST_SEL_WAITI: cmd.cap_b = 1'b1;
         dkse_pkg::ST_SEL_SWAP: begin
            cmd.wr_en = 1'b1; cmd.wr_sel = dkse_pkg::ADDR_I;
            cmd.wr_data_sel = dkse_pkg::DATA_A;
            cmd.inc_mov = 1'b1;
         end
         dkse_pkg::ST_SEL_SWAP2: begin
            cmd.wr_en = 1'b1; cmd.wr_sel = dkse_pkg::ADDR_BEST;
            cmd.wr_data_sel = dkse_pkg::DATA_B;
            cmd.inc_i = 1'b1;
         end
         dkse_pkg::ST_INS_RD: begin
            if (sts.i_lt_n) begin
               cmd.rd_en = 1'b1; cmd.rd_sel = dkse_pkg::ADDR_I;
               cmd.set_j_i = 1'b1;
            end else begin
               cmd.set_i_zero = 1'b1;
            end
         end
         dkse_pkg::ST_INS_WAIT: cmd.cap_held = 1'b1;
         dkse_pkg::ST_INS_TRD: begin
            // Reaching the front of the store still counts one comparison.
            if (sts.j_zero) begin
               cmd.inc_cmp = 1'b1;
            end else begin
               cmd.rd_en = 1'b1; cmd.rd_sel = dkse_pkg::ADDR_J_PREV;
            end
         end
         dkse_pkg::ST_INS_TWAIT: cmd.cap_b = 1'b1;
         dkse_pkg::ST_INS_CMP: begin
            cmd.inc_cmp = 1'b1;
            if (!sts.held_later_b) begin
               cmd.wr_en = 1'b1; cmd.wr_sel = dkse_pkg::ADDR_J;
               cmd.wr_data_sel = dkse_pkg::DATA_B;
               cmd.dec_j = 1'b1;
               cmd.inc_mov = 1'b1;
            end
         end
         dkse_pkg::ST_INS_PLACE: begin
            cmd.wr_en = 1'b1; cmd.wr_sel = dkse_pkg::ADDR_J;
            cmd.wr_data_sel = dkse_pkg::DATA_HELD;
            cmd.inc_mov = 1'b1;
            cmd.inc_i = 1'b1;
         end
         dkse_pkg::ST_OUT_RD: begin
            if (sts.i_lt_n) begin
               cmd.rd_en = 1'b1; cmd.rd_sel = dkse_pkg::ADDR_I;
            end else begin
               cmd.clr_count = 1'b1;
            end
         end
         dkse_pkg::ST_OUT_WAIT:
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               cmd.inc_i = 1'b1;
               rsp_valid_in = 1'b1;
               last_in = sts.last_rec;
            end
         default: ;
      endcase
   end
endmodule

// ===== hw/rtl/dkse_checker.sv =====
// Port-level checker for the date key sort engine, bound to the top level.
module dkse_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_last_out,
   input logic [11:0] rsp_comparisons,
   input logic [11:0] rsp_moves
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("output word dropped while stalled");
   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_comparisons) && $stable(rsp_moves)
         && $stable(rsp_last_out))
      else $error("output word changed while stalled");
   a_counts_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && !$past(rsp_last_out) |-> $stable(rsp_comparisons))
      else $error("comparison count changed within a run");
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_out |-> req_stall)
      else $error("input taken while a run is being emitted");
endmodule

bind date_key_sort_engine_unit dkse_checker u_dkse_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_last_out, .rsp_comparisons, .rsp_moves
);

// ===== sim/tb_top.sv =====
// Testbench of the date key sort engine: directed and random record sets, predicted results.
`timescale 1ns / 100ps

module tb_top;

   localparam int STORE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [15:0] tag;
   } date_rec_type;

   typedef struct packed {
      date_rec_type rec;
      logic [11:0]  comparisons;
      logic [11:0]  moves;
      logic         last_out;
   } sorted_word_type;

   typedef struct {
      date_rec_type rec;
      bit           fin;
      bit           typed;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [13:0] req_birth_year;
   logic [3:0]  req_birth_month;
   logic [4:0]  req_birth_day;
   logic [15:0] req_record_tag;
   logic        req_final_record;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [13:0] rsp_out_year;
   logic [3:0]  rsp_out_month;
   logic [4:0]  rsp_out_day;
   logic [15:0] rsp_out_tag;
   logic [11:0] rsp_comparisons;
   logic [11:0] rsp_moves;
   logic        rsp_last_out;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_algorithm;

   date_key_sort_engine_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_birth_year(req_birth_year), .req_birth_month(req_birth_month),
      .req_birth_day(req_birth_day), .req_record_tag(req_record_tag),
      .req_final_record(req_final_record),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_year(rsp_out_year), .rsp_out_month(rsp_out_month),
      .rsp_out_day(rsp_out_day), .rsp_out_tag(rsp_out_tag),
      .rsp_comparisons(rsp_comparisons), .rsp_moves(rsp_moves),
      .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_algorithm(csr_algorithm)
   );

   // Shadow of the block's state.
   date_rec_type      rec_mem[STORE_DEPTH];
   int                fill_count;
   logic [11:0]       cmp_count;
   logic [11:0]       move_count;
   dkse_pkg::alg_type sort_alg;

   sorted_word_type   sorted_q[$];
   int                error_count;
   int                cycle_count;
   bit                calm;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void bump(ref logic [11:0] c);
      if (c != dkse_pkg::CNT_MAX) c = c + 1'b1;
   endfunction

   function automatic bit later_than(date_rec_type a, date_rec_type b);
      return {a.year, a.month, a.day} > {b.year, b.month, b.day};
   endfunction

   function automatic void bubble_pass_sort(int n);
      date_rec_type t;
      int           swaps;
      for (int p = 0; p < n; p++) begin
         swaps = 0;
         for (int k = 1; k < n - p; k++) begin
            bump(cmp_count);
            if (later_than(rec_mem[k-1], rec_mem[k])) begin
               t = rec_mem[k-1];
               rec_mem[k-1] = rec_mem[k];
               rec_mem[k] = t;
               bump(move_count);
               swaps++;
            end
         end
         if (swaps == 0) break;
      end
   endfunction

   function automatic void selection_sort(int n);
      date_rec_type t;
      int           best;
      for (int p = 0; p < n; p++) begin
         best = p;
         for (int k = p + 1; k < n; k++) begin
            bump(cmp_count);
            if (later_than(rec_mem[best], rec_mem[k])) best = k;
         end
         if (best != p) begin
            bump(move_count);
            t = rec_mem[best];
            rec_mem[best] = rec_mem[p];
            rec_mem[p] = t;
         end
      end
   endfunction

   function automatic void insertion_sort(int n);
      date_rec_type held;
      int           slot;
      for (int p = 1; p < n; p++) begin
         held = rec_mem[p];
         slot = p;
         // Equal keys are shifted too, so only a strictly later held record stops.
         while (slot > 0) begin
            bump(cmp_count);
            if (!later_than(held, rec_mem[slot-1])) begin
               rec_mem[slot] = rec_mem[slot-1];
               slot--;
               bump(move_count);
            end else begin
               break;
            end
         end
         if (slot == 0) bump(cmp_count);
         rec_mem[slot] = held;
         bump(move_count);
      end
   endfunction

   // Takes one accepted record and returns the words it releases.
   function automatic void take_record(date_rec_type r, bit fin,
                                       ref sorted_word_type words[$]);
      int n;
      words.delete();
      if (fill_count < STORE_DEPTH) begin
         rec_mem[fill_count] = r;
         fill_count++;
      end
      if (!fin) return;
      n = fill_count;
      cmp_count = '0;
      move_count = '0;
      case (sort_alg)
         dkse_pkg::ALG_SELECTION: selection_sort(n);
         dkse_pkg::ALG_INSERTION: insertion_sort(n);
         default: bubble_pass_sort(n);
      endcase
      for (int k = 0; k < n; k++)
         words.push_back('{rec_mem[k], cmp_count, move_count, (k + 1 == n)});
      fill_count = 0;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   task automatic send_record(date_rec_type r, bit fin, bit typed);
      sorted_word_type words[$];
      int              gap;
      req_valid <= 1'b1;
      req_birth_year <= r.year;
      req_birth_month <= r.month;
      req_birth_day <= r.day;
      req_record_tag <= r.tag;
      req_final_record <= fin;
      do @(posedge clock); while (req_stall);
      take_record(r, fin, words);
      // A lone final record comes back unchanged with no work counted.
      if (typed) begin
         words.delete();
         words.push_back('{r, 12'd0, 12'd0, 1'b1});
      end
      foreach (words[i]) sorted_q.push_back(words[i]);
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sorted_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_alg(dkse_pkg::alg_type a);
      csr_valid <= 1'b1;
      csr_algorithm <= a;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sort_alg = a;
   endtask

   function automatic date_rec_type rand_record(int year_pool);
      date_rec_type r;
      // A narrow year pool makes equal and near-equal keys common.
      if (year_pool > 0) r.year = 14'(1990 + $urandom_range(0, year_pool - 1));
      else r.year = 14'($urandom_range(0, 16383));
      r.month = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 12));
      r.day = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 1) * 31)
                                          : 5'($urandom_range(0, 31));
      r.tag = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   task automatic send_set(int n);
      int pool;
      pool = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      for (int k = 0; k < n; k++)
         send_record(rand_record(pool), k == n - 1, 1'b0);
   endtask

   // Result side: check every accepted word, then pick the next stall.
   initial begin
      int              stall_left;
      sorted_word_type got;
      sorted_word_type want;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '{'{rsp_out_year, rsp_out_month, rsp_out_day, rsp_out_tag},
                    rsp_comparisons, rsp_moves, rsp_last_out};
            if (sorted_q.size() == 0) begin
               $display("%0t: unexpected word, actual %p", $time, got);
               error_count++;
            end else begin
               want = sorted_q.pop_front();
               if (got.rec.year != want.rec.year) begin
                  $display("%0t: year expected %0d actual %0d", $time, want.rec.year,
                           got.rec.year);
                  error_count++;
               end
               if (got.rec.month != want.rec.month) begin
                  $display("%0t: month expected %0d actual %0d", $time, want.rec.month,
                           got.rec.month);
                  error_count++;
               end
               if (got.rec.day != want.rec.day) begin
                  $display("%0t: day expected %0d actual %0d", $time, want.rec.day,
                           got.rec.day);
                  error_count++;
               end
               if (got.rec.tag != want.rec.tag) begin
                  $display("%0t: tag expected %h actual %h", $time, want.rec.tag, got.rec.tag);
                  error_count++;
               end
               if (got.comparisons != want.comparisons) begin
                  $display("%0t: comparisons expected %0d actual %0d", $time,
                           want.comparisons, got.comparisons);
                  error_count++;
               end
               if (got.moves != want.moves) begin
                  $display("%0t: moves expected %0d actual %0d", $time, want.moves,
                           got.moves);
                  error_count++;
               end
               if (got.last_out != want.last_out) begin
                  $display("%0t: last_out expected %0b actual %0b", $time, want.last_out,
                           got.last_out);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = gap_len();
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type      rows[$];
      dkse_pkg::alg_type phase_algs[$];
      int                phase_items;
      int                n;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_birth_year <= '0;
      req_birth_month <= '0;
      req_birth_day <= '0;
      req_record_tag <= '0;
      req_final_record <= 1'b0;
      csr_valid <= 1'b0;
      csr_algorithm <= dkse_pkg::ALG_BUBBLE;
      error_count = 0;
      fill_count = 0;
      cmp_count = '0;
      move_count = '0;
      sort_alg = dkse_pkg::ALG_BUBBLE;
      calm = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = '{
         '{'{14'd0, 4'd1, 5'd1, 16'h0000}, 1'b1, 1'b1},
         '{'{14'h3FFF, 4'hF, 5'h1F, 16'hFFFF}, 1'b1, 1'b1},
         '{'{14'd0, 4'd0, 5'd0, 16'h0000}, 1'b1, 1'b1},
         '{'{14'd9999, 4'd12, 5'd31, 16'h5555}, 1'b0, 1'b0},
         '{'{14'd9999, 4'd12, 5'd30, 16'hAAAA}, 1'b0, 1'b0},
         '{'{14'd0, 4'd1, 5'd1, 16'h0001}, 1'b1, 1'b0},
         '{'{14'd2000, 4'd6, 5'd15, 16'h0011}, 1'b0, 1'b0},
         '{'{14'd2000, 4'd6, 5'd15, 16'h0012}, 1'b0, 1'b0},
         '{'{14'd2000, 4'd6, 5'd15, 16'h0013}, 1'b1, 1'b0},
         '{'{14'd40, 4'd2, 5'd9, 16'h0100}, 1'b0, 1'b0},
         '{'{14'd30, 4'd11, 5'd3, 16'h0200}, 1'b0, 1'b0},
         '{'{14'd20, 4'd7, 5'd20, 16'h0300}, 1'b0, 1'b0},
         '{'{14'd10, 4'd4, 5'd1, 16'h0400}, 1'b1, 1'b0},
         '{'{14'd1999, 4'd12, 5'd1, 16'h0007}, 1'b0, 1'b0},
         '{'{14'd1999, 4'd1, 5'd31, 16'h0008}, 1'b1, 1'b0}
      };
      foreach (rows[i]) send_record(rows[i].rec, rows[i].fin, rows[i].typed);
      drain();

      phase_algs = '{dkse_pkg::ALG_SELECTION, dkse_pkg::ALG_INSERTION,
                     dkse_pkg::ALG_SPARE, dkse_pkg::ALG_BUBBLE,
                     dkse_pkg::ALG_INSERTION, dkse_pkg::ALG_SELECTION};
      foreach (phase_algs[p]) begin
         write_alg(phase_algs[p]);
         calm = (p == 3);
         phase_items = 0;
         // One overfilled store and one exactly full store.
         if (p == 1) begin
            send_set(66);
            phase_items += 66;
         end
         if (p == 2) begin
            send_set(STORE_DEPTH);
            phase_items += STORE_DEPTH;
         end
         while (phase_items < 10) begin
            n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
            send_set(n);
            phase_items += n;
            if (p == 0 && phase_items < 10) begin
               // Hold the sender until the whole set has come back.
               req_valid <= 1'b0;
               while (sorted_q.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dkse_pkg.sv
hw/rtl/dkse_datapath.sv
hw/rtl/dkse_ctrl.sv
hw/rtl/date_key_sort_engine_unit.sv
hw/rtl/dkse_checker.sv
sim/tb_top.sv
